### rtl/fssm_pkg.sv
// shared types and codes for the fieldbus slave state machine
package fssm_pkg;

	localparam int InWidth  = 104;
	localparam int OutWidth = 16;

	typedef enum logic [3:0] {
		ST_INIT   = 4'd1,
		ST_PREOP  = 4'd2,
		ST_SAFEOP = 4'd4,
		ST_OP     = 4'd8
	} slave_state_t;

	typedef enum logic [2:0] {
		KIND_NONE       = 3'd0,
		KIND_TRANSITION = 3'd1,
		KIND_MAILBOX    = 3'd2,
		KIND_PDATA      = 3'd3,
		KIND_SYNC       = 3'd4,
		KIND_WATCHDOG   = 3'd5
	} err_kind_t;

	// persistent machine state
	typedef struct packed {
		logic [3:0] st;
		logic       err;
		logic [2:0] kind;
		logic       ov;
	} esm_state_t;

	// one poll as unpacked from the input transfer
	typedef struct packed {
		logic [4:0]  control_word;
		logic [15:0] mbx_out_length;
		logic [15:0] mbx_in_length;
		logic [15:0] pd_out_length;
		logic [15:0] pd_in_length;
		logic [7:0]  mbx_out_activate;
		logic [7:0]  mbx_in_activate;
		logic [7:0]  pd_out_activate;
		logic [7:0]  pd_in_activate;
		logic        watchdog_fired;
		logic        clock_sync_enabled;
	} poll_t;

	// event pulses of one poll
	typedef struct packed {
		logic left_op;
		logic entered_preop;
		logic entered_safeop;
		logic entered_op;
		logic outputs_invalidated;
		logic watchdog_clear;
	} esm_events_t;

endpackage

### rtl/fssm_decide.sv
// next-state and event decision for one poll
module fssm_decide (
	input  fssm_pkg::poll_t      poll,
	input  fssm_pkg::esm_state_t cur,
	input  logic                 clock_sync_required,
	output fssm_pkg::esm_state_t nxt,
	output fssm_pkg::esm_events_t ev
);
	import fssm_pkg::*;

	logic [3:0] req;
	logic       ack;
	logic       mbx_ok;
	logic       pd_ok;

	assign req = poll.control_word[3:0];
	assign ack = poll.control_word[4];
	assign mbx_ok = (poll.mbx_out_length != 16'd0) && (poll.mbx_in_length != 16'd0)
		&& (poll.mbx_out_activate != 8'd0) && (poll.mbx_in_activate != 8'd0);
	assign pd_ok = (poll.pd_out_length != 16'd0) && (poll.pd_in_length != 16'd0)
		&& (poll.pd_out_activate != 8'd0) && (poll.pd_in_activate != 8'd0);

	always_comb begin
		nxt = cur;
		ev  = '0;
		if (ack && cur.err) begin
			nxt.err  = 1'b0;
			nxt.kind = KIND_NONE;
		end
		if (poll.watchdog_fired) begin
			ev.watchdog_clear = 1'b1;
			nxt.ov   = 1'b0;
			nxt.err  = 1'b1;
			nxt.kind = KIND_WATCHDOG;
		end
		if ((req != cur.st) && !nxt.err) begin
			case (req)
				ST_INIT: begin
					ev.left_op = (cur.st == ST_OP);
					nxt.ov = 1'b0;
					nxt.st = ST_INIT;
				end
				ST_PREOP: begin
					if (!mbx_ok) begin
						nxt.err  = 1'b1;
						nxt.kind = KIND_MAILBOX;
					end else begin
						ev.left_op       = (cur.st == ST_OP);
						ev.entered_preop = 1'b1;
						nxt.st = ST_PREOP;
					end
					nxt.ov = 1'b0;
				end
				ST_SAFEOP: begin
					if (cur.st != ST_PREOP) begin
						nxt.err  = 1'b1;
						nxt.kind = KIND_TRANSITION;
					end else if (!pd_ok) begin
						nxt.err  = 1'b1;
						nxt.kind = KIND_PDATA;
					end else begin
						ev.entered_safeop = 1'b1;
						nxt.st = ST_SAFEOP;
					end
					nxt.ov = 1'b0;
				end
				ST_OP: begin
					if (cur.st != ST_SAFEOP) begin
						nxt.err  = 1'b1;
						nxt.kind = KIND_TRANSITION;
						nxt.ov   = 1'b0;
					end else if (clock_sync_required && !poll.clock_sync_enabled) begin
						nxt.err  = 1'b1;
						nxt.kind = KIND_SYNC;
						nxt.ov   = 1'b0;
					end else begin
						ev.entered_op = 1'b1;
						nxt.ov = 1'b1;
						nxt.st = ST_OP;
					end
				end
				default: begin
					nxt.err  = 1'b1;
					nxt.kind = KIND_TRANSITION;
					nxt.ov   = 1'b0;
				end
			endcase
		end
		ev.outputs_invalidated = cur.ov && !nxt.ov;
	end

endmodule

### rtl/fieldbus_slave_state_machine_top.sv
// top level of the fieldbus slave state machine
//
//  channel   direction  width  contents
//  s_*       in         104    one poll of the master's registers
//  m_*       out        16     state, error and event flags after the poll
//  cfg_*     in         1      clock_sync_required register write
//
// one poll per cycle while results are not stalled; the decision is a single combinational
// pass from the input transfer into the result register, and the state updates on the same edge
// reset clears the state to init with no error, outputs invalid, register 0
// a stalled result holds in the output register; a new poll is taken whenever
// the result register is empty or being emptied in the same cycle
module fieldbus_slave_state_machine_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// control_word[4:0], mbx_out_length[20:5], mbx_in_length[36:21],
	// pd_out_length[52:37], pd_in_length[68:53], mbx_out_activate[76:69],
	// mbx_in_activate[84:77], pd_out_activate[92:85], pd_in_activate[100:93],
	// watchdog_fired[101], clock_sync_enabled[102], zero[103]
	input  logic [fssm_pkg::InWidth-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// current_state[3:0], error_pending[4], error_kind[7:5], outputs_valid[8],
	// left_op[9], entered_preop[10], entered_safeop[11], entered_op[12],
	// outputs_invalidated[13], watchdog_clear[14], zero[15]
	output logic [fssm_pkg::OutWidth-1:0] m_tdata
);
	import fssm_pkg::*;

	poll_t       poll;
	esm_state_t  state_q;
	esm_state_t  nxt;
	esm_events_t ev;
	logic        csr_q;
	logic        m_tvalid_q;
	logic [OutWidth-1:0] m_tdata_q;
	logic        take;

	// unpack the poll, first field in the low bits
	assign poll.control_word       = s_tdata[4:0];
	assign poll.mbx_out_length     = s_tdata[20:5];
	assign poll.mbx_in_length      = s_tdata[36:21];
	assign poll.pd_out_length      = s_tdata[52:37];
	assign poll.pd_in_length       = s_tdata[68:53];
	assign poll.mbx_out_activate   = s_tdata[76:69];
	assign poll.mbx_in_activate    = s_tdata[84:77];
	assign poll.pd_out_activate    = s_tdata[92:85];
	assign poll.pd_in_activate     = s_tdata[100:93];
	assign poll.watchdog_fired     = s_tdata[101];
	assign poll.clock_sync_enabled = s_tdata[102];

	// output register acts as the skid between the two sides
	assign s_tready = !m_tvalid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	fssm_decide u_decide (
		.poll                (poll),
		.cur                 (state_q),
		.clock_sync_required (csr_q),
		.nxt                 (nxt),
		.ev                  (ev)
	);

	// machine state and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.st   <= ST_INIT;
			state_q.err  <= 1'b0;
			state_q.kind <= KIND_NONE;
			state_q.ov   <= 1'b0;
			csr_q        <= 1'b0;
		end else begin
			if (take) begin
				state_q <= nxt;
			end
			if (cfg_we) begin
				csr_q <= cfg_wdata;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata_q <= {1'b0, ev.watchdog_clear, ev.outputs_invalidated, ev.entered_op,
				ev.entered_safeop, ev.entered_preop, ev.left_op, nxt.ov, nxt.kind,
				nxt.err, nxt.st};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### rtl/fssm_chk.sv
// port-level checker for the fieldbus slave state machine, with its bind
module fssm_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [fssm_pkg::OutWidth-1:0] m_tdata
);
	import fssm_pkg::*;

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a kind is reported exactly when an error is pending
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4] == (m_tdata[7:5] != KIND_NONE)))
		else $error("error kind and pending flag disagree");

	// entering op leaves the block in op with valid outputs
	a_op: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> (m_tdata[3:0] == ST_OP) && m_tdata[8])
		else $error("op entered without valid outputs");

	// an invalidation pulse never comes with valid outputs
	a_inv: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> !m_tdata[8])
		else $error("outputs invalidated but still valid");

	// the input side is open whenever no result is waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

endmodule

bind fieldbus_slave_state_machine_top fssm_chk u_fssm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
